// ----- hw/rtl/gcct_pkg.sv -----
// Shared types, codes and helpers of the card table engine.
// No dependencies.
package gcct_pkg;

  localparam int CARD_COUNT_DEF = 65536;
  localparam int CARD_SHIFT_DEF = 9;

  localparam int CARD_W  = 17;
  localparam int ADDR_W  = 48;
  localparam int SIZE_W  = 32;
  localparam int LOG2_W  = 6;
  localparam int WORD_W  = 64;
  localparam int IN_DW   = 168;
  localparam int OUT_DW  = 40;

  localparam logic [2:0] CMD_BARRIER = 3'd0;
  localparam logic [2:0] CMD_MARK    = 3'd1;
  localparam logic [2:0] CMD_TEST    = 3'd2;
  localparam logic [2:0] CMD_TCLR    = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;
  localparam logic [2:0] CMD_FIND    = 3'd5;
  localparam logic [2:0] CMD_QUERY   = 3'd6;

  localparam logic [1:0] REG_CONC  = 2'd0;
  localparam logic [1:0] REG_BASE  = 2'd1;
  localparam logic [1:0] REG_LOG2  = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE, OP_SET, OP_TEST, OP_CLEAR, OP_FIND
  } op_t;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_READ, S_MOD, S_OUT
  } state_t;

  function automatic logic [5:0] low_bit(input logic [WORD_W-1:0] w);
    logic [5:0] idx;
    idx = 6'd0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) idx = 6'(i);
    end
    return idx;
  endfunction

endpackage

// ----- hw/rtl/gc_card_table_engine.sv -----
// Top level of the card table engine: front decoder, two-entry queue, back sequencer.
// Depends on gcct_pkg, gcct_front, gcct_fifo and gcct_back.
//
//   channel  direction  carries
//   in_      slave      one command beat (tuser: cmd; tdata: see port)
//   out_     master     one result beat per command
//   cfg_     slave      register writes, index and data, always ready
//
// A single-card command (marking barrier, query) passes the back part's read, modify and
// output states; a barrier that marks nothing, the unused command and an empty find-next
// go straight to output. A range takes a read and a modify state per 64-card word it
// touches, a read-modify-write of the one-port-each RAM; find-next, per word searched.
// After reset a clearing pass writes CARD_COUNT/64 words, one per cycle, before the first
// command starts; the input is accepted into the queue meanwhile until it fills.
// CARD_COUNT must be a power of two. The input stalls only when the queue is full.
module gc_card_table_engine #(
  parameter int CARD_COUNT = gcct_pkg::CARD_COUNT_DEF,
  parameter int CARD_SHIFT = gcct_pkg::CARD_SHIFT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [gcct_pkg::ADDR_W-1:0] cfg_data,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // address[47:0], size[79:48], stored_value[127:80], first_card[144:128],
  // limit_card[161:145], zero fill
  input  logic [gcct_pkg::IN_DW-1:0]  in_tdata,
  // cmd[2:0]
  input  logic [2:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // hit[0], found_card[17:1], range_cards[34:18], zero fill
  output logic [gcct_pkg::OUT_DW-1:0] out_tdata
);
  import gcct_pkg::*;

  localparam int CW = $clog2(CARD_COUNT);
  localparam int FW = (CW + 1 > CARD_W) ? CW + 1 : CARD_W;
  localparam int ITEM_W = 3 + CW + (CW + 1) + 2 + 2 * FW + 2 * CARD_W;

  logic [ITEM_W-1:0] item_in, item_out;
  logic              q_full, q_empty, q_pop, push;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign push = in_tvalid && !q_full;

  gcct_front #(.CARD_COUNT(CARD_COUNT), .CARD_SHIFT(CARD_SHIFT), .ITEM_W(ITEM_W)) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(in_tuser),
    .address(in_tdata[47:0]),
    .size(in_tdata[79:48]),
    .stored_value(in_tdata[127:80]),
    .first_card(in_tdata[144:128]),
    .limit_card(in_tdata[161:145]),
    .item(item_in)
  );

  gcct_fifo #(.WIDTH(ITEM_W)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(item_in),
    .pop(q_pop), .pop_data(item_out), .full(q_full), .empty(q_empty)
  );

  gcct_back #(.CARD_COUNT(CARD_COUNT), .ITEM_W(ITEM_W)) u_back (
    .clk(clk), .rst_n(rst_n), .item(item_out), .q_empty(q_empty), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );
endmodule

// ----- hw/rtl/gcct_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gcct_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/gcct_fifo.sv -----
// Two-entry queue between the front and back parts.
// No dependencies.
module gcct_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= push_data;
  end
endmodule

// ----- hw/rtl/gcct_front.sv -----
// Front part: holds the configuration, decodes each input beat into a card operation.
// Depends on gcct_pkg.
module gcct_front #(
  parameter int CARD_COUNT = gcct_pkg::CARD_COUNT_DEF,
  parameter int CARD_SHIFT = gcct_pkg::CARD_SHIFT_DEF,
  parameter int ITEM_W     = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic [1:0]                  cfg_index,
  input  logic [gcct_pkg::ADDR_W-1:0] cfg_data,
  input  logic [2:0]                  cmd,
  input  logic [gcct_pkg::ADDR_W-1:0] address,
  input  logic [gcct_pkg::SIZE_W-1:0] size,
  input  logic [gcct_pkg::ADDR_W-1:0] stored_value,
  input  logic [gcct_pkg::CARD_W-1:0] first_card,
  input  logic [gcct_pkg::CARD_W-1:0] limit_card,
  output logic [ITEM_W-1:0]           item
);
  import gcct_pkg::*;

  localparam int CW = $clog2(CARD_COUNT);
  localparam int FW = (CW + 1 > CARD_W) ? CW + 1 : CARD_W;
  localparam int SW = ADDR_W + 1 - CARD_SHIFT;

  logic              conc_r;
  logic [ADDR_W-1:0] base_r;
  logic [LOG2_W-1:0] log2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conc_r <= 1'b0;
      base_r <= '0;
      log2_r <= LOG2_W'(22);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CONC: conc_r <= cfg_data[0];
        REG_BASE: base_r <= cfg_data;
        REG_LOG2: log2_r <= cfg_data[LOG2_W-1:0];
        default:  ;
      endcase
    end
  end

  logic [ADDR_W:0]   last_byte;
  logic [SW-1:0]     span;
  logic [CW:0]       n;
  logic [CW-1:0]     start;
  logic [ADDR_W-1:0] hi_mask;
  logic              young;
  logic [FW-1:0]     search_end;
  op_t               op;
  logic [CW:0]       cnt;
  logic              hitf, report;

  always_comb begin
    last_byte = {1'b0, address} + {17'd0, size} - {{ADDR_W{1'b0}}, (size != '0)};
    span = SW'(last_byte >> CARD_SHIFT) - SW'(address >> CARD_SHIFT) + SW'(1);
    n = (span > SW'(CARD_COUNT)) ? (CW+1)'(CARD_COUNT) : span[CW:0];
    start = address[CARD_SHIFT +: CW];
    hi_mask = ~((ADDR_W'(1) << log2_r) - ADDR_W'(1));
    young = (log2_r >= LOG2_W'(ADDR_W)) || (((stored_value ^ base_r) & hi_mask) == '0);
    search_end = (FW'(limit_card) < FW'(CARD_COUNT)) ? FW'(limit_card) : FW'(CARD_COUNT);
    op = OP_NONE;
    cnt = n;
    hitf = 1'b0;
    report = 1'b0;
    case (cmd)
      CMD_BARRIER: begin
        cnt = (CW+1)'(1);
        if (conc_r || young) begin
          op = OP_SET;
          hitf = 1'b1;
        end
      end
      CMD_MARK:  op = OP_SET;
      CMD_TEST: begin
        op = OP_TEST;
        report = 1'b1;
      end
      CMD_TCLR: begin
        op = OP_CLEAR;
        report = 1'b1;
      end
      CMD_CLEAR: op = OP_CLEAR;
      CMD_FIND:  op = OP_FIND;
      CMD_QUERY: begin
        op = OP_TEST;
        cnt = (CW+1)'(1);
        report = 1'b1;
      end
      default: op = OP_NONE;
    endcase
    item = {op, start, cnt, hitf, report, FW'(first_card), search_end, limit_card,
            CARD_W'(n)};
  end
endmodule

// ----- hw/rtl/gcct_back.sv -----
// Back part: walks card words in the table RAM and registers the result beat.
// Depends on gcct_pkg and gcct_ram.
module gcct_back #(
  parameter int CARD_COUNT = gcct_pkg::CARD_COUNT_DEF,
  parameter int ITEM_W     = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [ITEM_W-1:0]       item,
  input  logic                    q_empty,
  output logic                    q_pop,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [gcct_pkg::OUT_DW-1:0] out_tdata
);
  import gcct_pkg::*;

  localparam int CW = $clog2(CARD_COUNT);
  localparam int FW = (CW + 1 > CARD_W) ? CW + 1 : CARD_W;
  localparam int WD = CARD_COUNT / WORD_W;
  localparam int AW = $clog2(WD);

  op_t               i_op;
  logic [CW-1:0]     i_start;
  logic [CW:0]       i_cnt;
  logic              i_hitf, i_report;
  logic [FW-1:0]     i_first, i_end;
  logic [CARD_W-1:0] i_limit, i_rc;

  assign {i_op, i_start, i_cnt, i_hitf, i_report, i_first, i_end, i_limit, i_rc} = item;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [CW-1:0]     cur_r, cur_nxt;
  logic [CW:0]       cnt_r, cnt_nxt;
  logic              hitf_r, hitf_nxt, report_r, report_nxt, any_r, any_nxt;
  logic [FW-1:0]     pos_r, pos_nxt, end_r, end_nxt;
  logic [CARD_W-1:0] rc_r, rc_nxt;
  logic              hit_r, hit_nxt;
  logic [CARD_W-1:0] found_r, found_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic              ov_r, ov_nxt;
  logic [OUT_DW-1:0] od_r, od_nxt;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata;

  gcct_ram #(.WIDTH(WORD_W), .DEPTH(WD)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [5:0]        bofs;
  logic [6:0]        take;
  logic [WORD_W-1:0] mask, bits;
  logic              any_w, range_done, find_last;
  logic [FW-1:0]     pos_found, pos_step;
  logic              load_out;

  // Shared per-word arithmetic of the modify cycle.
  always_comb begin
    bofs = (op_r == OP_FIND) ? pos_r[5:0] : cur_r[5:0];
    take = 7'(WORD_W) - {1'b0, bofs};
    if ((CW+1)'(take) > cnt_r) take = 7'(cnt_r);
    // A full word gives 1 << 64 == 0, so the subtraction yields all ones.
    mask = ((WORD_W'(1) << take) - WORD_W'(1)) << bofs;
    any_w = any_r | ((rdata & mask) != '0);
    range_done = (cnt_r == (CW+1)'(take));
    bits = rdata & ({WORD_W{1'b1}} << bofs);
    pos_found = {pos_r[FW-1:6], low_bit(bits)};
    pos_step = {pos_r[FW-1:6] + (FW-6)'(1), 6'd0};
    find_last = (bits != '0) || (pos_step >= end_r);
    load_out = !ov_r || out_tready;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (clr_r == AW'(WD - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (!q_empty) begin
          if (i_op == OP_NONE || (i_op == OP_FIND && i_first >= i_end)) state_nxt = S_OUT;
          else state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_MOD;
      S_MOD: begin
        if (op_r == OP_FIND) state_nxt = find_last ? S_OUT : S_READ;
        else state_nxt = range_done ? S_OUT : S_READ;
      end
      S_OUT:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt = op_r;
    cur_nxt = cur_r;
    cnt_nxt = cnt_r;
    hitf_nxt = hitf_r;
    report_nxt = report_r;
    any_nxt = any_r;
    pos_nxt = pos_r;
    end_nxt = end_r;
    rc_nxt = rc_r;
    hit_nxt = hit_r;
    found_nxt = found_r;
    clr_nxt = clr_r;
    ov_nxt = ov_r;
    od_nxt = od_r;
    q_pop = 1'b0;
    we = 1'b0;
    waddr = cur_r[CW-1:6];
    wdata = rdata;
    raddr = (op_r == OP_FIND) ? pos_r[CW-1:6] : cur_r[CW-1:6];
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (state_r)
      S_CLR: begin
        we = 1'b1;
        waddr = clr_r;
        wdata = '0;
        clr_nxt = clr_r + AW'(1);
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          op_nxt = i_op;
          cur_nxt = i_start;
          cnt_nxt = i_cnt;
          hitf_nxt = i_hitf;
          report_nxt = i_report;
          any_nxt = 1'b0;
          pos_nxt = i_first;
          end_nxt = i_end;
          rc_nxt = i_rc;
          hit_nxt = 1'b0;
          found_nxt = (i_op == OP_FIND) ? i_limit : '0;
        end
      end
      S_MOD: begin
        if (op_r == OP_FIND) begin
          pos_nxt = pos_step;
          if (bits != '0 && pos_found < end_r) begin
            hit_nxt = 1'b1;
            found_nxt = CARD_W'(pos_found);
          end
        end else begin
          any_nxt = any_w;
          we = (op_r == OP_SET) || (op_r == OP_CLEAR);
          wdata = (op_r == OP_SET) ? (rdata | mask) : (rdata & ~mask);
          cur_nxt = cur_r + CW'(take);
          cnt_nxt = cnt_r - (CW+1)'(take);
          hit_nxt = hitf_r | (report_r & any_w);
        end
      end
      S_OUT: begin
        if (load_out) begin
          ov_nxt = 1'b1;
          od_nxt = OUT_DW'({rc_r, found_r, hit_r});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      ov_r <= ov_nxt;
    end
    op_r <= op_nxt;
    cur_r <= cur_nxt;
    cnt_r <= cnt_nxt;
    hitf_r <= hitf_nxt;
    report_r <= report_nxt;
    any_r <= any_nxt;
    pos_r <= pos_nxt;
    end_r <= end_nxt;
    rc_r <= rc_nxt;
    hit_r <= hit_nxt;
    found_r <= found_nxt;
    od_r <= od_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
endmodule
